### rtl/cdq_pkg.sv
// Package for the circular deque core.
// Holds the default sizes, the request and status codes and the memory control struct.
// No dependencies.
package cdq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_SET_FRONT  = 3'd4,
    REQ_SET_REAR   = 3'd5,
    REQ_PEEK_FRONT = 3'd6,
    REQ_PEEK_REAR  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### rtl/cdq_req_if.sv
// Request channel interface of the circular deque core.
// Depends on cdq_pkg for the request code type.
interface cdq_req_if #(
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDefault
);
  logic                         valid;
  logic                         ready;
  cdq_pkg::req_e                req_type;
  logic signed [DATA_WIDTH-1:0] entry_value;

  modport source (output valid, output req_type, output entry_value, input ready);
  modport sink   (input valid, input req_type, input entry_value, output ready);
endinterface

### rtl/cdq_rsp_if.sv
// Response channel interface of the circular deque core.
// Depends on cdq_pkg for the status code type.
interface cdq_rsp_if #(
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDefault,
  parameter int unsigned CNT_WIDTH  = $clog2(cdq_pkg::DepthDefault + 1)
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] read_value;
  cdq_pkg::status_e             status;
  logic [CNT_WIDTH-1:0]         fill_count;

  modport source (output valid, output read_value, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input fill_count,
                  output ready);
endinterface

### rtl/cdq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

### rtl/cdq_ctrl.sv
// Front/rear index, entry count and response register control of the circular deque.
// Depends on cdq_pkg; drives the entry RAM through a mem_ctl_t, address and write data.
module cdq_ctrl #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDefault,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  cdq_pkg::req_e         req_type_i,
  input  logic [DATA_WIDTH-1:0] entry_value_i,
  output logic                  req_ready_o,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output cdq_pkg::status_e      status_o,
  output logic [CntW-1:0]       fill_count_o,
  output logic                  rd_sel_o,
  output cdq_pkg::mem_ctl_t     mem_o,
  output logic [IdxW-1:0]       mem_addr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o
);

  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             rd_sel_q, rd_sel_d;
  cdq_pkg::status_e status_q, status_d;
  logic             accept;
  logic             is_full, is_empty;
  logic [IdxW-1:0]  head_prev, head_next, tail_prev, tail_next;

  assign req_ready_o  = !rsp_valid_q || rsp_ready_i;
  assign accept       = req_valid_i && req_ready_o;
  assign is_full      = (count_q == CntFull);
  assign is_empty     = (count_q == '0);
  assign head_prev    = (head_q == '0) ? IdxLast : head_q - 1'b1;
  assign head_next    = (head_q == IdxLast) ? '0 : head_q + 1'b1;
  assign tail_prev    = (tail_q == '0) ? IdxLast : tail_q - 1'b1;
  assign tail_next    = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;
  assign mem_wdata_o  = entry_value_i;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    status_d    = status_q;
    rd_sel_d    = rd_sel_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    mem_o       = '0;
    mem_addr_o  = head_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
      status_d    = cdq_pkg::ST_DONE;
      rd_sel_d    = 1'b0;
      unique case (req_type_i)
        cdq_pkg::REQ_PUSH_FRONT: begin
          if (is_full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            mem_o.we = 1'b1;
            count_d  = count_q + 1'b1;
            if (is_empty) begin
              tail_d     = head_q;
              mem_addr_o = head_q;
            end else begin
              head_d     = head_prev;
              mem_addr_o = head_prev;
            end
          end
        end
        cdq_pkg::REQ_PUSH_REAR: begin
          if (is_full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            mem_o.we = 1'b1;
            count_d  = count_q + 1'b1;
            if (is_empty) begin
              head_d     = tail_q;
              mem_addr_o = tail_q;
            end else begin
              tail_d     = tail_next;
              mem_addr_o = tail_next;
            end
          end
        end
        cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
          if (is_empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            mem_o.re = 1'b1;
            rd_sel_d = 1'b1;
            count_d  = count_q - 1'b1;
            if (req_type_i == cdq_pkg::REQ_POP_FRONT) begin
              mem_addr_o = head_q;
              if (count_q > CntW'(1)) head_d = head_next;
            end else begin
              mem_addr_o = tail_q;
              if (count_q > CntW'(1)) tail_d = tail_prev;
            end
          end
        end
        cdq_pkg::REQ_SET_FRONT, cdq_pkg::REQ_SET_REAR: begin
          if (is_empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            mem_o.we   = 1'b1;
            mem_addr_o = (req_type_i == cdq_pkg::REQ_SET_FRONT) ? head_q : tail_q;
          end
        end
        cdq_pkg::REQ_PEEK_FRONT, cdq_pkg::REQ_PEEK_REAR: begin
          if (is_empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            mem_o.re   = 1'b1;
            rd_sel_d   = 1'b1;
            mem_addr_o = (req_type_i == cdq_pkg::REQ_PEEK_FRONT) ? head_q : tail_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
      status_q    <= cdq_pkg::ST_DONE;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      rd_sel_q    <= rd_sel_d;
      status_q    <= status_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign status_o     = status_q;
  assign fill_count_o = count_q;
  assign rd_sel_o     = rd_sel_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count above depth");

  a_mem_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && mem_o.re))
    else $error("read and write issued together");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.re |-> !is_empty)
    else $error("read issued on empty deque");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != cdq_pkg::ST_DONE) |=>
      (count_q == $past(count_q) && head_q == $past(head_q) && tail_q == $past(tail_q)))
    else $error("rejected request changed state");

  a_rd_sel_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rd_sel_q) |-> status_q == cdq_pkg::ST_DONE)
    else $error("read data selected on rejected request");

endmodule

### rtl/circular_deque_core.sv
// Circular deque core: top level joining the index/count control and the entry RAM.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if, cdq_ctrl and cdq_ram.
//
// A double-ended queue of DEPTH entries held in one single-port synchronous RAM. Each
// request (push, pop, overwrite or peek at either end) yields exactly one response in the
// cycle after it is accepted, carrying the value read (zero if none), a status (done, full
// or empty) and the entry count after the request. One request is taken every clock cycle;
// the single output register stalls intake only while its response waits to be taken.
// The RAM's read data is registered like the response; a write in one cycle is seen by a
// read in the next, so no forwarding is needed.
module circular_deque_core #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_req_if.sink   req_i,
  cdq_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cdq_pkg::mem_ctl_t     mem_ctl;
  logic [IdxW-1:0]       mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                  rd_sel;
  logic [CntW-1:0]       fill_count;

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_type_i    (req_i.req_type),
    .entry_value_i (req_i.entry_value),
    .req_ready_o   (req_i.ready),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .status_o      (rsp_o.status),
    .fill_count_o  (fill_count),
    .rd_sel_o      (rd_sel),
    .mem_o         (mem_ctl),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata)
  );

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.we),
    .re_i    (mem_ctl.re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.read_value = rd_sel ? mem_rdata : '0;
  assign rsp_o.fill_count = fill_count;

endmodule

### sim/tb_circular_deque_core.sv
// Self-checking testbench for circular_deque_core: directed and biased random requests,
// each response checked against a scoreboard that predicts the deque's contents.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if and the circular_deque_core RTL.
module tb_circular_deque_core;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef struct {
    logic [DATA_W-1:0] read_value;
    cdq_pkg::status_e  status;
    logic [CNT_W-1:0]  fill_count;
  } deque_rsp_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  tail;
    logic [CNT_W-1:0]  count;
    deque_rsp_t        rsp_q[$];
    int                errors;
    int                checked;
    int                full_seen;
    int                empty_seen;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head       = '0;
      tail       = '0;
      count      = '0;
      errors     = 0;
      checked    = 0;
      full_seen  = 0;
      empty_seen = 0;
    endfunction

    function void note_request(cdq_pkg::req_e op, logic [DATA_W-1:0] val);
      deque_rsp_t       r;
      logic [IDX_W-1:0] slot;
      logic             front;
      r.read_value = '0;
      r.status     = cdq_pkg::ST_DONE;
      front = (op == cdq_pkg::REQ_PUSH_FRONT) || (op == cdq_pkg::REQ_POP_FRONT) ||
              (op == cdq_pkg::REQ_SET_FRONT) || (op == cdq_pkg::REQ_PEEK_FRONT);
      if (op == cdq_pkg::REQ_PUSH_FRONT || op == cdq_pkg::REQ_PUSH_REAR) begin
        if (count == DEPTH) begin
          r.status = cdq_pkg::ST_FULL;
        end else if (front) begin
          if (count == 0) tail = head;
          else head = (head == 0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
          slots[head] = val;
          count++;
        end else begin
          if (count == 0) head = tail;
          else tail = (tail == IDX_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
          slots[tail] = val;
          count++;
        end
      end else if (count == 0) begin
        r.status = cdq_pkg::ST_EMPTY;
      end else begin
        slot = front ? head : tail;
        case (op)
          cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
            r.read_value = slots[slot];
            if (count > 1) begin
              if (front) head = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
              else tail = (tail == 0) ? IDX_W'(DEPTH - 1) : tail - 1'b1;
            end
            count--;
          end
          cdq_pkg::REQ_SET_FRONT, cdq_pkg::REQ_SET_REAR: slots[slot] = val;
          default: r.read_value = slots[slot];
        endcase
      end
      r.fill_count = count;
      rsp_q.push_back(r);
    endfunction

    function void check_response(logic [DATA_W-1:0] rd, logic [1:0] st,
                                 logic [CNT_W-1:0] cnt);
      deque_rsp_t r;
      if (rsp_q.size() == 0) begin
        $error("unrequested response: read_value %0h status %0d fill_count %0d", rd, st, cnt);
        errors++;
        return;
      end
      r = rsp_q.pop_front();
      checked++;
      if (r.status == cdq_pkg::ST_FULL) full_seen++;
      if (r.status == cdq_pkg::ST_EMPTY) empty_seen++;
      if (rd !== r.read_value) begin
        $error("read_value: expected %0h actual %0h", r.read_value, rd);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d actual %0d", r.status, st);
        errors++;
      end
      if (cnt !== r.fill_count) begin
        $error("fill_count: expected %0d actual %0d", r.fill_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cdq_req_if #(.DATA_WIDTH(DATA_W)) req ();
  cdq_rsp_if #(.DATA_WIDTH(DATA_W), .CNT_WIDTH(CNT_W)) rsp ();

  circular_deque_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  deque_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rsp_hold_left = 0;
  int items_sent    = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && req.valid && req.ready) sb.note_request(req.req_type, req.entry_value);
    if (rst_ni && rsp.valid && rsp.ready)
      sb.check_response(rsp.read_value, rsp.status, rsp.fill_count);
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(cdq_pkg::req_e op, logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.req_type    <= op;
    req.entry_value <= val;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.rsp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(DATA_W - 1){1'b1}}};
      3:       return {1'b1, {(DATA_W - 1){1'b0}}};
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Bursts lean toward pushes or pops so the count swings between empty and full.
  function automatic cdq_pkg::req_e pick_op(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct)
      return $urandom_range(1) ? cdq_pkg::REQ_PUSH_REAR : cdq_pkg::REQ_PUSH_FRONT;
    if (roll < push_pct + pop_pct)
      return $urandom_range(1) ? cdq_pkg::REQ_POP_REAR : cdq_pkg::REQ_POP_FRONT;
    return cdq_pkg::req_e'($urandom_range(4, 7));
  endfunction

  task automatic run_random(int n_items, int hold_at);
    int left;
    int push_pct;
    int pop_pct;
    left = 0;
    push_pct = 0;
    pop_pct = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        left = $urandom_range(20, 50);
        case ($urandom_range(9))
          0:       begin push_pct = 25; pop_pct = 25; end
          1, 2, 3, 4: begin push_pct = 65; pop_pct = 15; end
          default: begin push_pct = 15; pop_pct = 65; end
        endcase
      end
      left--;
      if (i == hold_at) rsp_hold_left = 300;
      send_item(pick_op(push_pct, pop_pct), pick_value());
    end
  endtask

  initial begin
    #2000000;
    $display("circular_deque_core regression: fail");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni          = 1'b0;
    req.valid       = 1'b0;
    req.req_type    = cdq_pkg::REQ_PUSH_FRONT;
    req.entry_value = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 66;
    // empty deque rejects every non-push request
    send_item(cdq_pkg::REQ_POP_FRONT, '1);
    send_item(cdq_pkg::REQ_POP_REAR, '1);
    send_item(cdq_pkg::REQ_SET_FRONT, '1);
    send_item(cdq_pkg::REQ_SET_REAR, '1);
    send_item(cdq_pkg::REQ_PEEK_FRONT, '0);
    send_item(cdq_pkg::REQ_PEEK_REAR, '0);
    send_item(cdq_pkg::REQ_PUSH_FRONT, {1'b0, {(DATA_W - 1){1'b1}}});
    send_item(cdq_pkg::REQ_PEEK_REAR, '0);
    send_item(cdq_pkg::REQ_POP_FRONT, '0);
    send_item(cdq_pkg::REQ_PUSH_REAR, {1'b1, {(DATA_W - 1){1'b0}}});
    send_item(cdq_pkg::REQ_PUSH_FRONT, '1);
    send_item(cdq_pkg::REQ_PEEK_FRONT, '0);
    send_item(cdq_pkg::REQ_PEEK_REAR, '0);
    send_item(cdq_pkg::REQ_SET_FRONT, '0);
    send_item(cdq_pkg::REQ_SET_REAR, '1);
    send_item(cdq_pkg::REQ_POP_REAR, '0);
    send_item(cdq_pkg::REQ_POP_REAR, '0);
    send_item(cdq_pkg::REQ_POP_FRONT, '0);
    run_random(530, -1);
    wait_drained();

    send_idle_pct = 66;
    recv_idle_pct = 37;
    run_random(530, -1);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(530, 150);
    wait_drained();

    $display("ran %0d requests and checked %0d responses", items_sent, sb.checked);
    $display("rejects seen: %0d full, %0d empty", sb.full_seen, sb.empty_seen);
    if (sb.errors == 0) begin
      $display("circular_deque_core regression: pass");
    end else begin
      $display("circular_deque_core regression: fail");
    end
    $finish;
  end

endmodule
